// ===== src/ptnl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptnl_pkg: shared types and constants for the ping-pong trace lookup
// Payload structs, command codes, internal operation codes and FSM states.
// ----------------------------------------------------------------------------
package ptnl_pkg;

  localparam int BANK_CAPACITY_DEF = 128;
  localparam int QUEUE_DEPTH       = 2;
  localparam int ENTRY_W           = 96;

  // Command codes of the input transaction
  localparam logic [1:0] CMD_SWAP   = 2'd0;
  localparam logic [1:0] CMD_RECORD = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        address;
    logic [31:0]        tag;
    logic signed [31:0] payload;
  } ptnl_in_t;

  typedef struct packed {
    logic               lower_found;
    logic [31:0]        lower_address;
    logic [31:0]        lower_tag;
    logic signed [31:0] lower_payload;
    logic               upper_found;
    logic [31:0]        upper_address;
    logic [31:0]        upper_tag;
    logic signed [31:0] upper_payload;
  } ptnl_out_t;

  typedef enum logic [1:0] {
    OP_SWAP,
    OP_RECORD,
    OP_LOOKUP
  } ptnl_op_t;

  typedef struct packed {
    ptnl_op_t           op;
    logic [31:0]        address;
    logic [31:0]        tag;
    logic signed [31:0] payload;
  } ptnl_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ptnl_state_t;

endpackage

// ===== src/ptnl_ram.sv =====
// ----------------------------------------------------------------------------
// ptnl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/ptnl_front.sv =====
// ----------------------------------------------------------------------------
// ptnl_front: input stage
// Accept input transactions, decode the command and hand them to the queue.
// ----------------------------------------------------------------------------
module ptnl_front
  import ptnl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ptnl_in_t   in_data,
  output logic       push_valid,
  input  logic       push_ready,
  output ptnl_item_t push_item
);

  logic       vld_r;
  logic       vld_nxt;
  ptnl_item_t item_r;
  ptnl_item_t item_nxt;
  logic       keep;
  logic       accept;

  // Decode; the unused code is dropped here and never reaches the back end
  always_comb begin
    keep             = 1'b1;
    item_nxt.address = in_data.address;
    item_nxt.tag     = in_data.tag;
    item_nxt.payload = in_data.payload;
    unique case (in_data.command)
      CMD_SWAP:   item_nxt.op = OP_SWAP;
      CMD_RECORD: item_nxt.op = OP_RECORD;
      CMD_LOOKUP: item_nxt.op = OP_LOOKUP;
      default: begin
        item_nxt.op = OP_SWAP;
        keep        = 1'b0;
      end
    endcase
  end

  assign in_stall = vld_r & ~push_ready;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = keep;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = vld_r;
  assign push_item  = item_r;

endmodule

// ===== src/ptnl_queue.sv =====
// ----------------------------------------------------------------------------
// ptnl_queue: short command queue
// Decouple the input stage from the execution engine.
// ----------------------------------------------------------------------------
module ptnl_queue
  import ptnl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  ptnl_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output ptnl_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptnl_item_t    mem_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// ===== src/ptnl_back.sv =====
// ----------------------------------------------------------------------------
// ptnl_back: execution engine
// Run swaps and records as they are popped; scan the idle bank for a lookup.
// ----------------------------------------------------------------------------
module ptnl_back
  import ptnl_pkg::*;
#(
  parameter int BANK_CAPACITY = BANK_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       trace_enabled,
  input  logic       q_valid,
  output logic       q_ready,
  input  ptnl_item_t q_item,
  output logic       out_valid,
  input  logic       out_stall,
  output ptnl_out_t  out_data
);

  localparam int CW = $clog2(BANK_CAPACITY + 1);
  localparam int AW = $clog2(2 * BANK_CAPACITY);
  localparam int IW = (BANK_CAPACITY > 1) ? $clog2(BANK_CAPACITY) : 1;

  ptnl_state_t state_r;
  ptnl_state_t state_nxt;

  logic          active_r;
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] n_r;
  logic [IW-1:0] idx_r;
  logic          cmp_pend_r;
  logic [31:0]   query_r;

  logic               lo_ok_r;
  logic [31:0]        lo_best_r;
  logic [31:0]        lo_tag_r;
  logic signed [31:0] lo_pay_r;
  logic               hi_ok_r;
  logic [31:0]        hi_best_r;
  logic [31:0]        hi_tag_r;
  logic signed [31:0] hi_pay_r;

  logic      out_valid_r;
  ptnl_out_t out_data_r;

  logic                pop;
  logic                scan_last;
  logic                out_free;
  logic                out_load;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  rd_data;
  logic [31:0]         e_addr;
  logic [31:0]         e_tag;
  logic signed [31:0]  e_pay;

  ptnl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 * BANK_CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign e_addr    = rd_data[95:64];
  assign e_tag     = rd_data[63:32];
  assign e_pay     = rd_data[31:0];
  assign scan_last = (state_r == ST_SCAN) && ((CW'(idx_r) + CW'(1)) == n_r);
  assign out_free  = ~out_valid_r | ~out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_LOOKUP) begin
          state_nxt = (cnt_r[~active_r] == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop      = (state_r == ST_IDLE) && q_valid;
    rd_en    = (state_r == ST_SCAN);
    rd_addr  = (active_r ? AW'(0) : AW'(BANK_CAPACITY)) + AW'(idx_r);
    wr_en    = pop && (q_item.op == OP_RECORD) && trace_enabled &&
               (cnt_r[active_r] < CW'(BANK_CAPACITY));
    wr_addr  = (active_r ? AW'(BANK_CAPACITY) : AW'(0)) + AW'(cnt_r[active_r]);
    wr_data  = {q_item.address, q_item.tag, q_item.payload};
    out_load = (state_r == ST_DONE) && out_free;
  end

  assign q_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmp_pend_r <= rd_en;
      // Load a new result, else drop the one just taken
      out_valid_r <= out_load | (out_valid_r & out_stall);
      if (pop && q_item.op == OP_SWAP) begin
        active_r        <= ~active_r;
        cnt_r[~active_r] <= '0;
      end
      if (wr_en) begin
        cnt_r[active_r] <= cnt_r[active_r] + CW'(1);
      end
    end

    // Datapath: no reset needed
    if (pop && q_item.op == OP_LOOKUP) begin
      query_r   <= q_item.address;
      n_r       <= cnt_r[~active_r];
      idx_r     <= '0;
      lo_ok_r   <= 1'b0;
      lo_best_r <= '0;
      lo_tag_r  <= '0;
      lo_pay_r  <= '0;
      hi_ok_r   <= 1'b0;
      hi_best_r <= '1;
      hi_tag_r  <= '0;
      hi_pay_r  <= '0;
    end
    if (rd_en) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmp_pend_r) begin
      // Strict compares keep the earliest entry on equal addresses
      if (query_r >= e_addr && lo_best_r < e_addr) begin
        lo_ok_r   <= 1'b1;
        lo_best_r <= e_addr;
        lo_tag_r  <= e_tag;
        lo_pay_r  <= e_pay;
      end
      if (query_r < e_addr && e_addr < hi_best_r) begin
        hi_ok_r   <= 1'b1;
        hi_best_r <= e_addr;
        hi_tag_r  <= e_tag;
        hi_pay_r  <= e_pay;
      end
    end
    if (out_load) begin
      out_data_r.lower_found   <= lo_ok_r;
      out_data_r.lower_address <= lo_best_r;
      out_data_r.lower_tag     <= lo_tag_r;
      out_data_r.lower_payload <= lo_pay_r;
      out_data_r.upper_found   <= hi_ok_r;
      out_data_r.upper_address <= hi_ok_r ? hi_best_r : 32'd0;
      out_data_r.upper_tag     <= hi_tag_r;
      out_data_r.upper_payload <= hi_pay_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/pingpong_trace_nearest_lookup_top.sv =====
// ----------------------------------------------------------------------------
// pingpong_trace_nearest_lookup_top: double-buffered trace table
// Records go to the active bank; lookups search the other bank for the
// nearest entries at or below and above a query address.
// ----------------------------------------------------------------------------
// Two banks of BANK_CAPACITY entries (address, tag, signed payload) share one
// RAM. A swap transaction flips the active bank and empties it; a record
// appends to the active bank while trace_enabled is set and the bank has
// room, and is dropped otherwise; a lookup walks the inactive bank in entry
// order and returns one result transaction with the closest nonzero address
// not above the query and the closest address above the query that is not
// all-ones (first entry wins on equal addresses, zeros when not found).
// Command code 3 is dropped at the input. Swaps and records execute as they
// are taken and do not hold the engine. A lookup holds the execution engine
// while it takes the command, reads the bank's n filled entries (n at most
// BANK_CAPACITY) through the single RAM read port, one entry per cycle,
// compares the last entry once its read data returns, and loads the result
// register, which waits while an earlier result is still stalled; an empty
// bank skips the reads and compares. A small queue in front of the engine
// keeps accepting transactions while a lookup runs, until it is full.
// Storage needs no clearing after reset: only filled entries are ever read.
// ----------------------------------------------------------------------------
module pingpong_trace_nearest_lookup_top
  import ptnl_pkg::*;
#(
  parameter int BANK_CAPACITY = BANK_CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  // configuration
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  // input transactions
  input  logic      in_valid,
  output logic      in_stall,
  input  ptnl_in_t  in_data,
  // result transactions
  output logic      out_valid,
  input  logic      out_stall,
  output ptnl_out_t out_data
);

  logic       trace_enabled_r;
  logic       push_valid;
  logic       push_ready;
  ptnl_item_t push_item;
  logic       q_valid;
  logic       q_ready;
  ptnl_item_t q_item;

  // Single configuration bit; the user must write it only while the engine is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_enabled_r <= 1'b0;
    end else if (cfg_wr_en) begin
      trace_enabled_r <= cfg_wr_data;
    end
  end

  // Front end: accept and decode, drop the unused command code
  ptnl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Hold decoded transactions while a lookup occupies the engine
  ptnl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back end: bank bookkeeping, RAM, scan and result register
  ptnl_back #(
    .BANK_CAPACITY (BANK_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .trace_enabled (trace_enabled_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
